/* hdl/c8enc_pkg.sv */
// Shared types, codes and the instruction format table for the CHIP-8 instruction encoder.
// Depends on nothing; used by c8enc_match and chip8_instruction_encoder_unit.

package c8enc_pkg;

	localparam int unsigned FMT_COUNT = 46;

	localparam logic [4:0] MN_CLS  = 5'd0;
	localparam logic [4:0] MN_RET  = 5'd1;
	localparam logic [4:0] MN_JP   = 5'd2;
	localparam logic [4:0] MN_CALL = 5'd3;
	localparam logic [4:0] MN_SE   = 5'd4;
	localparam logic [4:0] MN_SNE  = 5'd5;
	localparam logic [4:0] MN_LD   = 5'd6;
	localparam logic [4:0] MN_ADD  = 5'd7;
	localparam logic [4:0] MN_OR   = 5'd8;
	localparam logic [4:0] MN_AND  = 5'd9;
	localparam logic [4:0] MN_SUB  = 5'd10;
	localparam logic [4:0] MN_SHR  = 5'd11;
	localparam logic [4:0] MN_SUBN = 5'd12;
	localparam logic [4:0] MN_SHL  = 5'd13;
	localparam logic [4:0] MN_RND  = 5'd14;
	localparam logic [4:0] MN_DRW  = 5'd15;
	localparam logic [4:0] MN_SKP  = 5'd16;
	localparam logic [4:0] MN_SKNP = 5'd17;
	localparam logic [4:0] MN_XOR  = 5'd18;
	localparam logic [4:0] MN_SCD  = 5'd19;
	localparam logic [4:0] MN_SCR  = 5'd20;
	localparam logic [4:0] MN_SCL  = 5'd21;
	localparam logic [4:0] MN_EXIT = 5'd22;
	localparam logic [4:0] MN_LOW  = 5'd23;
	localparam logic [4:0] MN_HIGH = 5'd24;
	localparam logic [4:0] MN_JPV0 = 5'd25;

	// Operand kinds, followed by the integer slot kinds used only in the table.
	localparam logic [3:0] KD_NONE = 4'd0;
	localparam logic [3:0] KD_V    = 4'd1;
	localparam logic [3:0] KD_INT  = 4'd2;
	localparam logic [3:0] KD_DT   = 4'd3;
	localparam logic [3:0] KD_ST   = 4'd4;
	localparam logic [3:0] KD_I    = 4'd5;
	localparam logic [3:0] KD_IP   = 4'd6;
	localparam logic [3:0] KD_K    = 4'd7;
	localparam logic [3:0] KD_F    = 4'd8;
	localparam logic [3:0] KD_B    = 4'd9;
	localparam logic [3:0] KD_HF   = 4'd10;
	localparam logic [3:0] KD_R    = 4'd11;
	localparam logic [3:0] SL_N4   = 4'd12;
	localparam logic [3:0] SL_N8   = 4'd13;
	localparam logic [3:0] SL_N12  = 4'd14;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_TOO_BIG  = 2'd1;
	localparam logic [1:0] ST_NO_MATCH = 2'd2;

	localparam logic [15:0] MK_NONE = 16'h0000;
	localparam logic [15:0] MK_X    = 16'h0F00;
	localparam logic [15:0] MK_Y    = 16'h00F0;
	localparam logic [15:0] MK_N    = 16'h000F;
	localparam logic [15:0] MK_KK   = 16'h00FF;
	localparam logic [15:0] MK_NNN  = 16'h0FFF;

	typedef struct packed {
		logic [4:0]  mnem;
		logic [15:0] base;
		logic [1:0]  count;
		logic [3:0]  slot_a;
		logic [3:0]  slot_b;
		logic [3:0]  slot_c;
		logic [15:0] mask_a;
		logic [15:0] mask_b;
		logic [15:0] mask_c;
	} fmt_t;

	typedef struct packed {
		logic [4:0]  mnemonic;
		logic [1:0]  operand_count;
		logic [3:0]  kind_a;
		logic [11:0] value_a;
		logic [3:0]  kind_b;
		logic [11:0] value_b;
		logic [3:0]  kind_c;
		logic [11:0] value_c;
	} instr_t;

	typedef struct packed {
		logic [15:0] opcode;
		logic [1:0]  status;
	} result_t;

	localparam fmt_t FMT_TABLE [FMT_COUNT] = '{
		'{MN_SCD,  16'h00C0, 2'd1, SL_N4,   KD_NONE, KD_NONE, MK_N,    MK_NONE, MK_NONE},
		'{MN_CLS,  16'h00E0, 2'd0, KD_NONE, KD_NONE, KD_NONE, MK_NONE, MK_NONE, MK_NONE},
		'{MN_RET,  16'h00EE, 2'd0, KD_NONE, KD_NONE, KD_NONE, MK_NONE, MK_NONE, MK_NONE},
		'{MN_SCR,  16'h00FB, 2'd0, KD_NONE, KD_NONE, KD_NONE, MK_NONE, MK_NONE, MK_NONE},
		'{MN_SCL,  16'h00FC, 2'd0, KD_NONE, KD_NONE, KD_NONE, MK_NONE, MK_NONE, MK_NONE},
		'{MN_EXIT, 16'h00FD, 2'd0, KD_NONE, KD_NONE, KD_NONE, MK_NONE, MK_NONE, MK_NONE},
		'{MN_LOW,  16'h00FE, 2'd0, KD_NONE, KD_NONE, KD_NONE, MK_NONE, MK_NONE, MK_NONE},
		'{MN_HIGH, 16'h00FF, 2'd0, KD_NONE, KD_NONE, KD_NONE, MK_NONE, MK_NONE, MK_NONE},
		'{MN_JP,   16'h1000, 2'd1, SL_N12,  KD_NONE, KD_NONE, MK_NNN,  MK_NONE, MK_NONE},
		'{MN_CALL, 16'h2000, 2'd1, SL_N12,  KD_NONE, KD_NONE, MK_NNN,  MK_NONE, MK_NONE},
		'{MN_SE,   16'h3000, 2'd2, KD_V,    SL_N8,   KD_NONE, MK_X,    MK_KK,   MK_NONE},
		'{MN_SNE,  16'h4000, 2'd2, KD_V,    SL_N8,   KD_NONE, MK_X,    MK_KK,   MK_NONE},
		'{MN_SE,   16'h5000, 2'd2, KD_V,    KD_V,    KD_NONE, MK_X,    MK_Y,    MK_NONE},
		'{MN_LD,   16'h6000, 2'd2, KD_V,    SL_N8,   KD_NONE, MK_X,    MK_KK,   MK_NONE},
		'{MN_ADD,  16'h7000, 2'd2, KD_V,    SL_N8,   KD_NONE, MK_X,    MK_KK,   MK_NONE},
		'{MN_LD,   16'h8000, 2'd2, KD_V,    KD_V,    KD_NONE, MK_X,    MK_Y,    MK_NONE},
		'{MN_OR,   16'h8001, 2'd2, KD_V,    KD_V,    KD_NONE, MK_X,    MK_Y,    MK_NONE},
		'{MN_AND,  16'h8002, 2'd2, KD_V,    KD_V,    KD_NONE, MK_X,    MK_Y,    MK_NONE},
		'{MN_XOR,  16'h8003, 2'd2, KD_V,    KD_V,    KD_NONE, MK_X,    MK_Y,    MK_NONE},
		'{MN_ADD,  16'h8004, 2'd2, KD_V,    KD_V,    KD_NONE, MK_X,    MK_Y,    MK_NONE},
		'{MN_SUB,  16'h8005, 2'd2, KD_V,    KD_V,    KD_NONE, MK_X,    MK_Y,    MK_NONE},
		'{MN_SHR,  16'h8006, 2'd2, KD_V,    KD_V,    KD_NONE, MK_X,    MK_Y,    MK_NONE},
		'{MN_SHR,  16'h8006, 2'd1, KD_V,    KD_NONE, KD_NONE, MK_X,    MK_NONE, MK_NONE},
		'{MN_SUBN, 16'h8007, 2'd2, KD_V,    KD_V,    KD_NONE, MK_X,    MK_Y,    MK_NONE},
		'{MN_SHL,  16'h800E, 2'd2, KD_V,    KD_V,    KD_NONE, MK_X,    MK_Y,    MK_NONE},
		'{MN_SHL,  16'h800E, 2'd1, KD_V,    KD_NONE, KD_NONE, MK_X,    MK_NONE, MK_NONE},
		'{MN_SNE,  16'h9000, 2'd2, KD_V,    KD_V,    KD_NONE, MK_X,    MK_Y,    MK_NONE},
		'{MN_LD,   16'hA000, 2'd2, KD_I,    SL_N12,  KD_NONE, MK_NONE, MK_NNN,  MK_NONE},
		'{MN_JPV0, 16'hB000, 2'd1, SL_N12,  KD_NONE, KD_NONE, MK_NNN,  MK_NONE, MK_NONE},
		'{MN_JP,   16'hB000, 2'd2, KD_V,    SL_N12,  KD_NONE, MK_NONE, MK_NNN,  MK_NONE},
		'{MN_RND,  16'hC000, 2'd2, KD_V,    SL_N8,   KD_NONE, MK_X,    MK_KK,   MK_NONE},
		'{MN_DRW,  16'hD000, 2'd3, KD_V,    KD_V,    SL_N4,   MK_X,    MK_Y,    MK_N},
		'{MN_SKP,  16'hE09E, 2'd1, KD_V,    KD_NONE, KD_NONE, MK_X,    MK_NONE, MK_NONE},
		'{MN_SKNP, 16'hE0A1, 2'd1, KD_V,    KD_NONE, KD_NONE, MK_X,    MK_NONE, MK_NONE},
		'{MN_LD,   16'hF007, 2'd2, KD_V,    KD_DT,   KD_NONE, MK_X,    MK_NONE, MK_NONE},
		'{MN_LD,   16'hF00A, 2'd2, KD_V,    KD_K,    KD_NONE, MK_X,    MK_NONE, MK_NONE},
		'{MN_LD,   16'hF015, 2'd2, KD_DT,   KD_V,    KD_NONE, MK_NONE, MK_X,    MK_NONE},
		'{MN_LD,   16'hF018, 2'd2, KD_ST,   KD_V,    KD_NONE, MK_NONE, MK_X,    MK_NONE},
		'{MN_ADD,  16'hF01E, 2'd2, KD_I,    KD_V,    KD_NONE, MK_NONE, MK_X,    MK_NONE},
		'{MN_LD,   16'hF029, 2'd2, KD_F,    KD_V,    KD_NONE, MK_NONE, MK_X,    MK_NONE},
		'{MN_LD,   16'hF030, 2'd2, KD_HF,   KD_V,    KD_NONE, MK_NONE, MK_X,    MK_NONE},
		'{MN_LD,   16'hF033, 2'd2, KD_B,    KD_V,    KD_NONE, MK_NONE, MK_X,    MK_NONE},
		'{MN_LD,   16'hF055, 2'd2, KD_IP,   KD_V,    KD_NONE, MK_NONE, MK_X,    MK_NONE},
		'{MN_LD,   16'hF065, 2'd2, KD_V,    KD_IP,   KD_NONE, MK_X,    MK_NONE, MK_NONE},
		'{MN_LD,   16'hF075, 2'd2, KD_R,    KD_V,    KD_NONE, MK_NONE, MK_X,    MK_NONE},
		'{MN_LD,   16'hF085, 2'd2, KD_V,    KD_R,    KD_NONE, MK_X,    MK_NONE, MK_NONE}
	};

endpackage

/* hdl/c8enc_match.sv */
// Combinational format matcher and opcode assembler for one registered instruction.
// Depends on c8enc_pkg for the format table, the operand codes and the shared structs.

module c8enc_match (
	input  c8enc_pkg::instr_t  instr,
	output c8enc_pkg::result_t result
);

	function automatic logic slot_ok(input logic [3:0] slot, input logic [3:0] kind,
			input logic [11:0] value);
		logic ok;
		ok = 1'b0;
		if (kind == c8enc_pkg::KD_INT) begin
			if (slot == c8enc_pkg::SL_N12) ok = 1'b1;
			else if (slot == c8enc_pkg::SL_N8) ok = (value[11:8] == 4'd0);
			else if (slot == c8enc_pkg::SL_N4) ok = (value[11:4] == 8'd0);
		end else if (kind != c8enc_pkg::KD_NONE && kind <= c8enc_pkg::KD_R) begin
			ok = (slot == kind);
		end
		return ok;
	endfunction

	function automatic logic [15:0] place(input logic [11:0] value, input logic [15:0] mask);
		logic [15:0] wide;
		wide = {4'd0, value};
		if (mask == c8enc_pkg::MK_X) wide = wide << 8;
		else if (mask == c8enc_pkg::MK_Y) wide = wide << 4;
		return wide & mask;
	endfunction

	logic [c8enc_pkg::FMT_COUNT-1:0] hit;
	logic [c8enc_pkg::FMT_COUNT-1:0] first;
	logic [15:0]                     word;
	logic                            reg_too_big;
	logic                            use_a;
	logic                            use_b;
	logic                            use_c;

	assign use_a = (instr.operand_count >= 2'd1);
	assign use_b = (instr.operand_count >= 2'd2);
	assign use_c = (instr.operand_count == 2'd3);

	assign reg_too_big =
		(use_a && instr.kind_a == c8enc_pkg::KD_V && instr.value_a[11:4] != 8'd0) ||
		(use_b && instr.kind_b == c8enc_pkg::KD_V && instr.value_b[11:4] != 8'd0) ||
		(use_c && instr.kind_c == c8enc_pkg::KD_V && instr.value_c[11:4] != 8'd0);

	always_comb begin
		for (int i = 0; i < c8enc_pkg::FMT_COUNT; i++) begin
			hit[i] = (c8enc_pkg::FMT_TABLE[i].mnem == instr.mnemonic) &&
				(c8enc_pkg::FMT_TABLE[i].count == instr.operand_count) &&
				(!use_a || slot_ok(c8enc_pkg::FMT_TABLE[i].slot_a, instr.kind_a, instr.value_a)) &&
				(!use_b || slot_ok(c8enc_pkg::FMT_TABLE[i].slot_b, instr.kind_b, instr.value_b)) &&
				(!use_c || slot_ok(c8enc_pkg::FMT_TABLE[i].slot_c, instr.kind_c, instr.value_c));
		end
	end

	// The earliest matching entry in table order wins.
	assign first = hit & (~hit + {{(c8enc_pkg::FMT_COUNT-1){1'b0}}, 1'b1});

	always_comb begin
		word = 16'd0;
		for (int i = 0; i < c8enc_pkg::FMT_COUNT; i++) begin
			if (first[i]) begin
				word = word | c8enc_pkg::FMT_TABLE[i].base |
					place(instr.value_a, use_a ? c8enc_pkg::FMT_TABLE[i].mask_a
						: c8enc_pkg::MK_NONE) |
					place(instr.value_b, use_b ? c8enc_pkg::FMT_TABLE[i].mask_b
						: c8enc_pkg::MK_NONE) |
					place(instr.value_c, use_c ? c8enc_pkg::FMT_TABLE[i].mask_c
						: c8enc_pkg::MK_NONE);
			end
		end
	end

	always_comb begin
		if (reg_too_big) begin
			result.opcode = 16'd0;
			result.status = c8enc_pkg::ST_TOO_BIG;
		end else if (hit == '0) begin
			result.opcode = 16'd0;
			result.status = c8enc_pkg::ST_NO_MATCH;
		end else begin
			result.opcode = word;
			result.status = c8enc_pkg::ST_OK;
		end
	end

endmodule

/* hdl/chip8_instruction_encoder_unit.sv */
// Top level of the CHIP-8 / SUPER-CHIP instruction encoder: input register, matcher, result register.
// Depends on c8enc_pkg and c8enc_match.

// Each transaction on the input carries one parsed instruction and yields exactly one
// transaction on the output, through the input register and then the result register, with
// the 16-bit opcode and a status (ok, register number too big, or no matching format; the
// opcode is zero unless the status is ok). A new instruction is taken in every cycle unless
// the input is stalled: the input register feeds a single pass through the format table into
// the result register, and the input stalls only while both registers hold instructions and
// the output is stalled. The block keeps no state between instructions.

module chip8_instruction_encoder_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [4:0]  mnemonic,
	input  logic [1:0]  operand_count,
	input  logic [3:0]  kind_a,
	input  logic [11:0] value_a,
	input  logic [3:0]  kind_b,
	input  logic [11:0] value_b,
	input  logic [3:0]  kind_c,
	input  logic [11:0] value_c,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] opcode,
	output logic [1:0]  status
);

	c8enc_pkg::instr_t  instr_s1;
	logic               valid_s1;
	c8enc_pkg::result_t enc;
	c8enc_pkg::result_t result_s2;
	logic               valid_s2;
	logic               adv_s2;
	logic               adv_s1;

	assign adv_s2   = !valid_s2 || !out_stall;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign in_stall = !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			instr_s1 <= '{mnemonic, operand_count, kind_a, value_a, kind_b, value_b,
				kind_c, value_c};
		end
	end

	c8enc_match u_match (
		.instr  (instr_s1),
		.result (enc)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			result_s2 <= enc;
		end
	end

	assign out_valid = valid_s2;
	assign opcode    = result_s2.opcode;
	assign status    = result_s2.status;

`ifndef ASSERT_OFF
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != c8enc_pkg::ST_OK |-> opcode == 16'd0)
		else $error("Opcode is not zero on an error status.");

	a_accept_loads: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> valid_s1)
		else $error("Accepted instruction did not reach the input register.");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid && out_stall)
		else $error("Input stalled while the pipeline had room.");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status == c8enc_pkg::ST_OK || status == c8enc_pkg::ST_TOO_BIG ||
			status == c8enc_pkg::ST_NO_MATCH)
		else $error("Status code out of range.");
`endif

endmodule
